@@ rtl/core/salru_pkg.sv @@
// package for the set-associative lru tag store
// types, sizes and outcome codes shared by all modules; no dependencies
package salru_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int STAMP_WIDTH  = 48;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ADDR_W       = 64;
    localparam int CNT_W        = 32;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        REG_SET_BITS    = 2'd0,
        REG_OFFSET_BITS = 2'd1,
        REG_WAYS_USED   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RESULT
    } state_t;

    // one line of a set as held in memory
    typedef struct packed {
        logic                   valid;
        logic [ADDR_W-1:0]      tag;
        logic [STAMP_WIDTH-1:0] stamp;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] set_row_t;

    // lookup decision handed back to the controller
    typedef struct packed {
        outcome_t         outcome;
        logic [WAY_W-1:0] way;
    } decision_t;

endpackage

@@ rtl/core/salru_if.sv @@
// valid/ready channel interfaces for the lru tag store
// depends on salru_pkg
interface salru_addr_if;
    logic                        valid;
    logic                        ready;
    logic [salru_pkg::ADDR_W-1:0] address;
    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

interface salru_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  outcome;
    logic [2:0]                  way_index;
    logic [salru_pkg::CNT_W-1:0] hit_count;
    logic [salru_pkg::CNT_W-1:0] miss_count;
    logic [salru_pkg::CNT_W-1:0] eviction_count;
    modport source (output valid, output outcome, output way_index, output hit_count,
                    output miss_count, output eviction_count, input ready);
    modport sink (input valid, input outcome, input way_index, input hit_count,
                  input miss_count, input eviction_count, output ready);
endinterface

interface salru_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [5:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/salru_mem.sv @@
// set memory: one row of all ways per set, one read and one write port
// depends on salru_pkg
module salru_mem (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [salru_pkg::SET_W-1:0]    rd_addr,
    output salru_pkg::set_row_t            rd_data,
    input  logic                           wr_en,
    input  logic [salru_pkg::SET_W-1:0]    wr_addr,
    input  salru_pkg::set_row_t            wr_data
);
    salru_pkg::set_row_t mem [salru_pkg::NUM_SETS];

    // synchronous write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ rtl/core/salru_pick.sv @@
// way selection: hit search, first empty way, oldest stamp
// depends on salru_pkg
module salru_pick (
    input  salru_pkg::set_row_t             row,
    input  logic [salru_pkg::ADDR_W-1:0]    tag,
    input  logic [salru_pkg::WAY_W:0]       nways,
    output salru_pkg::decision_t            dec
);
    logic [salru_pkg::MAX_WAYS-1:0] hit_vec;
    logic [salru_pkg::MAX_WAYS-1:0] empty_vec;
    logic [salru_pkg::WAY_W-1:0]    hit_way;
    logic [salru_pkg::WAY_W-1:0]    empty_way;
    logic [salru_pkg::WAY_W-1:0]    old_way;
    logic [salru_pkg::STAMP_WIDTH-1:0] old_stamp;

    // per-way match and empty flags
    always_comb
    begin
        for (int w = 0; w < salru_pkg::MAX_WAYS; w++)
        begin
            hit_vec[w]   = (w < nways) && row[w].valid && (row[w].tag == tag);
            empty_vec[w] = (w < nways) && !row[w].valid;
        end
    end

    // lowest set bit of each flag vector, oldest stamp among ways in use
    always_comb
    begin
        hit_way   = '0;
        empty_way = '0;
        old_way   = '0;
        old_stamp = row[0].stamp;
        for (int w = salru_pkg::MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = w[salru_pkg::WAY_W-1:0];
            end
            if (empty_vec[w])
            begin
                empty_way = w[salru_pkg::WAY_W-1:0];
            end
        end
        for (int w = 1; w < salru_pkg::MAX_WAYS; w++)
        begin
            if ((w < nways) && (row[w].stamp < old_stamp))
            begin
                old_stamp = row[w].stamp;
                old_way   = w[salru_pkg::WAY_W-1:0];
            end
        end
    end

    // final decision
    always_comb
    begin
        if (|hit_vec)
        begin
            dec.outcome = salru_pkg::OUT_HIT;
            dec.way     = hit_way;
        end
        else if (|empty_vec)
        begin
            dec.outcome = salru_pkg::OUT_FILL;
            dec.way     = empty_way;
        end
        else
        begin
            dec.outcome = salru_pkg::OUT_EVICT;
            dec.way     = old_way;
        end
    end
endmodule

@@ rtl/core/set_assoc_lru_cache_tags_top.sv @@
// lru tag store: takes one address at a time, in steps of accept, memory read
// with write back, move into the output register; the next address is taken
// only after the move. a result waiting in the output register only holds up
// the next access once that access has its own result.
// after reset a clearing pass over all 256 sets (one set a cycle) runs before the
// first access is taken. depends on salru_pkg, salru_if, salru_mem, salru_pick
module set_assoc_lru_cache_tags_top (
    input  logic          clk,
    input  logic          rst_n,
    salru_cfg_if.sink     cfg,
    salru_addr_if.sink    in_ch,
    salru_res_if.source   out_ch
);
    localparam int SW = salru_pkg::SET_W;
    localparam int WW = salru_pkg::WAY_W;

    salru_pkg::state_t state_reg, state_next;
    logic [SW:0]    clr_reg, clr_next;
    logic [3:0]     set_bits_reg;
    logic [5:0]     offset_bits_reg;
    logic [3:0]     ways_used_reg;
    logic [salru_pkg::ADDR_W-1:0] tag_reg, tag_next;
    logic [SW-1:0]  set_reg, set_next;
    logic [salru_pkg::STAMP_WIDTH-1:0] clock_reg;
    logic [salru_pkg::CNT_W-1:0] hits_reg, misses_reg, evicts_reg;
    logic [1:0]     outcome_reg;
    logic [WW-1:0]  way_reg;
    logic           ovalid_reg;
    logic [1:0]     oout_reg;
    logic [WW-1:0]  oway_reg;
    logic [salru_pkg::CNT_W-1:0] ohits_reg, omisses_reg, oevicts_reg;

    salru_pkg::set_row_t  rd_row, wr_row;
    logic                 wr_en, rd_en;
    logic [SW-1:0]        wr_addr;
    salru_pkg::decision_t dec;
    logic [WW:0]          nways;
    logic [3:0]           sb;
    logic [6:0]           tshift;
    logic [salru_pkg::ADDR_W-1:0] shifted;
    logic [salru_pkg::STAMP_WIDTH-1:0] stamp_new;
    logic                 out_load;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= '0;
            offset_bits_reg <= '0;
            ways_used_reg   <= 4'd1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                salru_pkg::REG_SET_BITS:    set_bits_reg    <= cfg.data[3:0];
                salru_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg.data;
                salru_pkg::REG_WAYS_USED:   ways_used_reg   <= cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // address split with clamped fields
    always_comb
    begin
        sb = (set_bits_reg > 4'(salru_pkg::MAX_SET_BITS))
             ? 4'(salru_pkg::MAX_SET_BITS) : set_bits_reg;
        if (ways_used_reg == 4'd0)
            nways = (WW+1)'(1);
        else if (ways_used_reg > 4'(salru_pkg::MAX_WAYS))
            nways = (WW+1)'(salru_pkg::MAX_WAYS);
        else
            nways = (WW+1)'(ways_used_reg);
        tshift   = 7'(sb) + 7'(offset_bits_reg);
        shifted  = in_ch.address >> offset_bits_reg;
        set_next = SW'(shifted & ((64'd1 << sb) - 64'd1));
        tag_next = (tshift >= 7'd64) ? '0 : (in_ch.address >> tshift);
    end

    salru_mem u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (set_next),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row)
    );

    salru_pick u_pick (
        .row   (rd_row),
        .tag   (tag_reg),
        .nways (nways),
        .dec   (dec)
    );

    assign stamp_new = clock_reg + 1'b1;

    // controller: clear pass, then accept, look up, hand result to output register
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        in_ch.ready  = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = set_reg;
        wr_row       = rd_row;
        out_load     = 1'b0;
        case (state_reg)
            salru_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[SW-1:0];
                wr_row  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SW+1)'(salru_pkg::NUM_SETS - 1))
                    state_next = salru_pkg::ST_IDLE;
            end
            salru_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                rd_en       = in_ch.valid;
                if (in_ch.valid)
                    state_next = salru_pkg::ST_LOOKUP;
            end
            salru_pkg::ST_LOOKUP:
            begin
                wr_en = 1'b1;
                wr_row[dec.way].valid = 1'b1;
                wr_row[dec.way].tag   = tag_reg;
                wr_row[dec.way].stamp = stamp_new;
                state_next = salru_pkg::ST_RESULT;
            end
            salru_pkg::ST_RESULT:
            begin
                out_load = !ovalid_reg || out_ch.ready;
                if (out_load)
                    state_next = salru_pkg::ST_IDLE;
            end
            default: state_next = salru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= salru_pkg::ST_CLEAR;
            clr_reg    <= '0;
            clock_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == salru_pkg::ST_LOOKUP)
            begin
                clock_reg <= stamp_new;
                if (dec.outcome == salru_pkg::OUT_HIT)
                begin
                    if (hits_reg != '1) hits_reg <= hits_reg + 1'b1;
                end
                else if (misses_reg != '1)
                begin
                    misses_reg <= misses_reg + 1'b1;
                end
                if (dec.outcome == salru_pkg::OUT_EVICT && evicts_reg != '1)
                    evicts_reg <= evicts_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == salru_pkg::ST_IDLE && in_ch.valid)
        begin
            tag_reg <= tag_next;
            set_reg <= set_next;
        end
        if (state_reg == salru_pkg::ST_LOOKUP)
        begin
            outcome_reg <= dec.outcome;
            way_reg     <= dec.way;
        end
        if (out_load)
        begin
            oout_reg    <= outcome_reg;
            oway_reg    <= way_reg;
            ohits_reg   <= hits_reg;
            omisses_reg <= misses_reg;
            oevicts_reg <= evicts_reg;
        end
    end

    // result transfer from the output register
    assign out_ch.valid          = ovalid_reg;
    assign out_ch.outcome        = oout_reg;
    assign out_ch.way_index      = oway_reg;
    assign out_ch.hit_count      = ohits_reg;
    assign out_ch.miss_count     = omisses_reg;
    assign out_ch.eviction_count = oevicts_reg;
endmodule
